// File: rtl/hmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the heartbeat membership table.
// Used by hmt_table, hmt_ctrl and heartbeat_membership_table_top; depends on nothing.
package hmt_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam int ID_W    = 32;
    localparam int PORT_W  = 16;
    localparam int BEAT_W  = 32;
    localparam int STAMP_W = 32;
    localparam int TMO_W   = 16;
    localparam int CMD_W   = 2;
    localparam int EV_W    = 3;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_JOIN_REQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_JOIN_REPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GOSSIP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd3;

    // Event codes
    localparam logic [EV_W-1:0] EV_REFRESHED    = 3'd0;
    localparam logic [EV_W-1:0] EV_STALE        = 3'd1;
    localparam logic [EV_W-1:0] EV_ADDED        = 3'd2;
    localparam logic [EV_W-1:0] EV_DROPPED      = 3'd3;
    localparam logic [EV_W-1:0] EV_REMOVED      = 3'd4;
    localparam logic [EV_W-1:0] EV_TICK_DONE    = 3'd5;
    localparam logic [EV_W-1:0] EV_TICK_IGNORED = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd20;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   member_id;
        logic [PORT_W-1:0] member_port;
        logic [BEAT_W-1:0] heartbeat;
        logic [STAMP_W-1:0] now;
    } req_item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [ID_W-1:0]   peer_id;
        logic [PORT_W-1:0] peer_port;
        logic [BEAT_W-1:0] beat_out;
        logic              send_reply;
        logic              last;
    } rsp_item_t;

    // One table entry as stored
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PORT_W-1:0]  port;
        logic [BEAT_W-1:0]  beat;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Write / valid-bit command from the controller to the table
    typedef struct packed {
        logic   we;
        logic   set_valid;
        logic   clr_valid;
        entry_t data;
    } tbl_wr_t;

    // Own-address rewrite on a configuration write
    typedef struct packed {
        logic              id_we;
        logic              port_we;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
    } cfg_upd_t;

endpackage

// File: rtl/hmt_table.sv
`timescale 1ns / 1ps
// Membership table storage: synchronous entry memory, entry zero in registers, valid bits.
// Depends on hmt_pkg.
module hmt_table #(
    parameter int TABLE_DEPTH = hmt_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IDX_W-1:0]          rd_addr,
    output hmt_pkg::entry_t           rd_entry,
    output logic                      rd_valid,
    input  logic [IDX_W-1:0]          wr_addr,
    input  hmt_pkg::tbl_wr_t          wr,
    input  hmt_pkg::cfg_upd_t         cfg_upd,
    input  logic [hmt_pkg::ID_W-1:0]  self_id,
    input  logic [hmt_pkg::PORT_W-1:0] self_port
);

    hmt_pkg::entry_t mem [TABLE_DEPTH];
    hmt_pkg::entry_t mem_q_reg;
    hmt_pkg::entry_t ent0_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic rd0_reg;
    logic rd_valid_reg;
    logic own0;

    // Entry zero keeps its reset contents and own-address rewrites in flops
    assign own0 = valid_reg[0] && (ent0_reg.id == self_id) && (ent0_reg.port == self_port);

    always_ff @(posedge clk)
    begin
        if (wr.we && (wr_addr != '0))
        begin
            mem[wr_addr] <= wr.data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent0_reg     <= '0;
            valid_reg    <= {{(TABLE_DEPTH-1){1'b0}}, 1'b1};
            rd0_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd0_reg      <= (rd_addr == '0);
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr.we && (wr_addr == '0))
            begin
                ent0_reg <= wr.data;
            end
            else if (cfg_upd.id_we && own0)
            begin
                ent0_reg.id <= cfg_upd.id;
            end
            else if (cfg_upd.port_we && own0)
            begin
                ent0_reg.port <= cfg_upd.port;
            end
            if (wr.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    assign rd_entry = rd0_reg ? ent0_reg : mem_q_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: rtl/hmt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: table sweep, timeout removal, refresh/add write-back and the result register.
// Depends on hmt_pkg; drives hmt_table.
module hmt_ctrl #(
    parameter int TABLE_DEPTH = hmt_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  hmt_pkg::req_item_t          req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output hmt_pkg::rsp_item_t          rsp_data,
    input  logic [hmt_pkg::ID_W-1:0]    self_id,
    input  logic [hmt_pkg::PORT_W-1:0]  self_port,
    input  logic [hmt_pkg::TMO_W-1:0]   remove_timeout,
    output logic [IDX_W-1:0]            rd_addr,
    input  hmt_pkg::entry_t             rd_entry,
    input  logic                        rd_valid,
    output logic [IDX_W-1:0]            wr_addr,
    output hmt_pkg::tbl_wr_t            wr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [hmt_pkg::BEAT_W-1:0] match_beat_reg, match_beat_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic                          tick_reg, tick_next;
    logic [hmt_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [hmt_pkg::ID_W-1:0]      key_id_reg, key_id_next;
    logic [hmt_pkg::PORT_W-1:0]    key_port_reg, key_port_next;
    logic [hmt_pkg::BEAT_W-1:0]    key_beat_reg, key_beat_next;
    logic [hmt_pkg::STAMP_W-1:0]   key_now_reg, key_now_next;
    logic [hmt_pkg::BEAT_W-1:0]    own_beat_reg, own_beat_next;
    logic                          in_group_reg, in_group_next;

    logic               rsp_valid_reg, rsp_valid_next;
    hmt_pkg::rsp_item_t rsp_reg, rsp_next;

    logic                        out_free;
    logic [hmt_pkg::STAMP_W-1:0] age;
    logic                        is_remove;
    logic                        vld_after;
    logic                        hit;
    logic                        stall;
    logic [hmt_pkg::EV_W-1:0]    ev;
    logic [hmt_pkg::BEAT_W-1:0]  beat;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign age       = key_now_reg - rd_entry.stamp;
    assign is_remove = tick_reg && rd_valid
                       && (age > {{(hmt_pkg::STAMP_W-hmt_pkg::TMO_W){1'b0}}, remove_timeout});
    assign vld_after = rd_valid && !is_remove;
    assign hit       = vld_after && (rd_entry.id == key_id_reg) && (rd_entry.port == key_port_reg);
    assign stall     = cmp_vld_reg && is_remove && !out_free;

    always_comb
    begin
        state_next       = state_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_beat_next  = match_beat_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        tick_next        = tick_reg;
        cmd_next         = cmd_reg;
        key_id_next      = key_id_reg;
        key_port_next    = key_port_reg;
        key_beat_next    = key_beat_reg;
        key_now_next     = key_now_reg;
        own_beat_next    = own_beat_reg;
        in_group_next    = in_group_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        rd_addr      = rd_idx_reg[IDX_W-1:0];
        wr_addr      = cmp_idx_reg;
        wr           = '0;
        wr.data.id   = key_id_reg;
        wr.data.port = key_port_reg;
        wr.data.beat = key_beat_reg;
        wr.data.stamp = key_now_reg;
        ev           = hmt_pkg::EV_DROPPED;
        beat         = key_beat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next         = req_data.command;
                    key_now_next     = req_data.now;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    rd_idx_next      = '0;
                    cmp_vld_next     = 1'b0;
                    if (req_data.command == hmt_pkg::CMD_TICK)
                    begin
                        tick_next = 1'b1;
                        if (in_group_reg)
                        begin
                            own_beat_next = own_beat_reg + 1'b1;
                            key_id_next   = self_id;
                            key_port_next = self_port;
                            key_beat_next = own_beat_reg + 1'b1;
                            state_next    = ST_SWEEP;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        tick_next     = 1'b0;
                        key_id_next   = req_data.member_id;
                        key_port_next = req_data.member_port;
                        key_beat_next = req_data.heartbeat;
                        state_next    = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP:
            begin
                if (stall)
                begin
                    // hold the compare stage and fetch its entry again
                    rd_addr = cmp_idx_reg;
                end
                else
                begin
                    if (cmp_vld_reg)
                    begin
                        if (is_remove)
                        begin
                            wr.clr_valid        = 1'b1;
                            rsp_valid_next      = 1'b1;
                            rsp_next.event_res  = hmt_pkg::EV_REMOVED;
                            rsp_next.peer_id    = rd_entry.id;
                            rsp_next.peer_port  = rd_entry.port;
                            rsp_next.beat_out   = rd_entry.beat;
                            rsp_next.send_reply = 1'b0;
                            rsp_next.last       = 1'b0;
                        end
                        if (!match_found_reg && hit)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = cmp_idx_reg;
                            match_beat_next  = rd_entry.beat;
                        end
                        if (!free_found_reg && !vld_after)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    if (rd_idx_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        cmp_vld_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (tick_reg && !in_group_reg)
                    begin
                        rsp_next.event_res  = hmt_pkg::EV_TICK_IGNORED;
                        rsp_next.peer_id    = '0;
                        rsp_next.peer_port  = '0;
                        rsp_next.beat_out   = '0;
                        rsp_next.send_reply = 1'b0;
                        rsp_next.last       = 1'b1;
                    end
                    else
                    begin
                        if (match_found_reg)
                        begin
                            if (key_beat_reg > match_beat_reg)
                            begin
                                wr.we   = 1'b1;
                                wr_addr = match_idx_reg;
                                ev      = hmt_pkg::EV_REFRESHED;
                            end
                            else
                            begin
                                ev   = hmt_pkg::EV_STALE;
                                beat = match_beat_reg;
                            end
                        end
                        else if (free_found_reg)
                        begin
                            wr.we        = 1'b1;
                            wr.set_valid = 1'b1;
                            wr_addr      = free_idx_reg;
                            ev           = hmt_pkg::EV_ADDED;
                        end
                        rsp_next.peer_id   = key_id_reg;
                        rsp_next.peer_port = key_port_reg;
                        rsp_next.last      = 1'b1;
                        if (tick_reg)
                        begin
                            rsp_next.event_res  = hmt_pkg::EV_TICK_DONE;
                            rsp_next.beat_out   = key_beat_reg;
                            rsp_next.send_reply = 1'b0;
                        end
                        else
                        begin
                            rsp_next.event_res  = ev;
                            rsp_next.beat_out   = beat;
                            rsp_next.send_reply = (cmd_reg == hmt_pkg::CMD_JOIN_REQ);
                            if (cmd_reg == hmt_pkg::CMD_JOIN_REPLY)
                            begin
                                in_group_next = 1'b1;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_idx_reg      <= '0;
            cmp_idx_reg     <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            match_beat_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            tick_reg        <= 1'b0;
            cmd_reg         <= '0;
            key_id_reg      <= '0;
            key_port_reg    <= '0;
            key_beat_reg    <= '0;
            key_now_reg     <= '0;
            own_beat_reg    <= '0;
            in_group_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_idx_reg     <= cmp_idx_next;
            cmp_vld_reg     <= cmp_vld_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            match_beat_reg  <= match_beat_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            tick_reg        <= tick_next;
            cmd_reg         <= cmd_next;
            key_id_reg      <= key_id_next;
            key_port_reg    <= key_port_next;
            key_beat_reg    <= key_beat_next;
            key_now_reg     <= key_now_next;
            own_beat_reg    <= own_beat_next;
            in_group_reg    <= in_group_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// File: rtl/heartbeat_membership_table_top.sv
`timescale 1ns / 1ps
// Top level of the heartbeat membership table: configuration registers and module wiring.
// Depends on hmt_pkg, hmt_table and hmt_ctrl.
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one message or tick beat.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns result beats; the final
//   beat of an item has last set. A tick in the group returns one removed beat
//   per expired entry, in index order, then a tick done beat.
//   cfg_we/cfg_index/cfg_data write self_id, self_port and remove_timeout;
//   write only while no item is in flight. Index 3 is ignored.
// Timing:
//   Every item except an ignored tick sweeps the whole table through the one
//   read port of the entry memory, one entry a cycle while the output register
//   is free or the entry does not expire, then writes back at most once. The
//   next item is accepted only after the final beat of the previous one is
//   registered; an ignored tick skips the sweep.
// Reset clears valid bits except entry zero (own entry, address zero), own heartbeat,
// group membership and the output register; there is no clearing pass.
// Backpressure: a beat waits in the output register; while it is held, the sweep
// holds at an expiring entry and the final step holds, until rsp_ready.
module heartbeat_membership_table_top #(
    parameter int TABLE_DEPTH = hmt_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  hmt_pkg::req_item_t               req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output hmt_pkg::rsp_item_t               rsp_data,
    input  logic                             cfg_we,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hmt_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [hmt_pkg::ID_W-1:0]   self_id_reg;
    logic [hmt_pkg::PORT_W-1:0] self_port_reg;
    logic [hmt_pkg::TMO_W-1:0]  timeout_reg;

    hmt_pkg::cfg_upd_t cfg_upd;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    hmt_pkg::entry_t   rd_entry;
    logic              rd_valid;
    hmt_pkg::tbl_wr_t  wr;

    // Own-address writes also rewrite entry zero when it still holds the old address
    assign cfg_upd.id_we   = cfg_we && (cfg_index == hmt_pkg::CFG_SELF_ID);
    assign cfg_upd.port_we = cfg_we && (cfg_index == hmt_pkg::CFG_SELF_PORT);
    assign cfg_upd.id      = cfg_data[hmt_pkg::ID_W-1:0];
    assign cfg_upd.port    = cfg_data[hmt_pkg::PORT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= '0;
            self_port_reg <= '0;
            timeout_reg   <= hmt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hmt_pkg::CFG_SELF_ID:   self_id_reg   <= cfg_data[hmt_pkg::ID_W-1:0];
                hmt_pkg::CFG_SELF_PORT: self_port_reg <= cfg_data[hmt_pkg::PORT_W-1:0];
                hmt_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data[hmt_pkg::TMO_W-1:0];
                default:                ; // drop writes beyond the register list
            endcase
        end
    end

    hmt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .cfg_upd   (cfg_upd),
        .self_id   (self_id_reg),
        .self_port (self_port_reg)
    );

    hmt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .self_id        (self_id_reg),
        .self_port      (self_port_reg),
        .remove_timeout (timeout_reg),
        .rd_addr        (rd_addr),
        .rd_entry       (rd_entry),
        .rd_valid       (rd_valid),
        .wr_addr        (wr_addr),
        .wr             (wr)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for heartbeat_membership_table_top: joins, gossip, ticks and sweeps,
// predicted in step with accepted beats. Depends on hmt_pkg and the RTL under rtl/.
module tb;

    localparam int DEPTH     = 32;
    localparam int POOL_SIZE = 40;
    // Index past the three registers; the block must ignore it.
    localparam logic [hmt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    hmt_pkg::req_item_t            req_data = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    hmt_pkg::rsp_item_t            rsp_data;
    logic                          cfg_we = 1'b0;
    logic [hmt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hmt_pkg::CFG_W-1:0]     cfg_data = '0;

    heartbeat_membership_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted membership table, own state and register copies.
    // ------------------------------------------------------------------
    logic                        mt_valid [DEPTH];
    logic [hmt_pkg::ID_W-1:0]    mt_id    [DEPTH];
    logic [hmt_pkg::PORT_W-1:0]  mt_port  [DEPTH];
    logic [hmt_pkg::BEAT_W-1:0]  mt_beat  [DEPTH];
    logic [hmt_pkg::STAMP_W-1:0] mt_stamp [DEPTH];
    logic [hmt_pkg::BEAT_W-1:0]  own_beat;
    logic                        joined;
    logic [hmt_pkg::ID_W-1:0]    own_id;
    logic [hmt_pkg::PORT_W-1:0]  own_port;
    logic [hmt_pkg::TMO_W-1:0]   age_limit;

    // Result beats still owed by the block, oldest first.
    hmt_pkg::rsp_item_t due_events[$];
    // Request beats waiting for the driver.
    hmt_pkg::req_item_t pending_q[$];

    int unsigned mismatch_cnt = 0;

    // Stimulus bookkeeping: a peer pool so that messages hit existing entries.
    logic [hmt_pkg::ID_W-1:0]    pool_id   [POOL_SIZE];
    logic [hmt_pkg::PORT_W-1:0]  pool_port [POOL_SIZE];
    logic [hmt_pkg::BEAT_W-1:0]  pool_beat [POOL_SIZE];
    logic [hmt_pkg::STAMP_W-1:0] wall_ticks;

    // Traffic shaping knobs, written by the sequencing block.
    logic steady = 1'b0;
    logic want_holdoff = 1'b0;

    // Append one expected result beat.
    function automatic void queue_due(input hmt_pkg::rsp_item_t r);
        due_events = {due_events, r};
    endfunction

    // Append one request beat for the driver.
    function automatic void queue_req(input hmt_pkg::req_item_t it);
        pending_q = {pending_q, it};
    endfunction

    // Refresh a matching entry on a newer beat (else report it stale), add an absent peer, or drop it on a full table.
    function automatic void merge_heartbeat(input logic [hmt_pkg::ID_W-1:0] id,
                                            input logic [hmt_pkg::PORT_W-1:0] port,
                                            input logic [hmt_pkg::BEAT_W-1:0] hb,
                                            input logic [hmt_pkg::STAMP_W-1:0] now,
                                            output logic [hmt_pkg::EV_W-1:0] ev,
                                            output logic [hmt_pkg::BEAT_W-1:0] kept);
        int free_slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (mt_valid[i] && mt_id[i] == id && mt_port[i] == port) begin
                if (hb > mt_beat[i]) begin
                    mt_beat[i]  = hb;
                    mt_stamp[i] = now;
                    kept = hb;
                    ev   = hmt_pkg::EV_REFRESHED;
                end
                else begin
                    kept = mt_beat[i];
                    ev   = hmt_pkg::EV_STALE;
                end
                return;
            end
            if (!mt_valid[i] && free_slot < 0)
                free_slot = i;
        end
        kept = hb;
        if (free_slot < 0)
            ev = hmt_pkg::EV_DROPPED;
        else begin
            mt_valid[free_slot] = 1'b1;
            mt_id[free_slot]    = id;
            mt_port[free_slot]  = port;
            mt_beat[free_slot]  = hb;
            mt_stamp[free_slot] = now;
            ev = hmt_pkg::EV_ADDED;
        end
    endfunction

    // Advance the predicted table by one accepted request and queue its results.
    function automatic void membership_update(input hmt_pkg::req_item_t it);
        hmt_pkg::rsp_item_t          r;
        logic [hmt_pkg::EV_W-1:0]    ev;
        logic [hmt_pkg::BEAT_W-1:0]  kept;
        logic [hmt_pkg::STAMP_W-1:0] age;
        r = '0;
        if (it.command != hmt_pkg::CMD_TICK) begin
            merge_heartbeat(it.member_id, it.member_port, it.heartbeat, it.now, ev, kept);
            if (it.command == hmt_pkg::CMD_JOIN_REPLY)
                joined = 1'b1;
            r.event_res  = ev;
            r.peer_id    = it.member_id;
            r.peer_port  = it.member_port;
            r.beat_out   = kept;
            r.send_reply = (it.command == hmt_pkg::CMD_JOIN_REQ);
            r.last       = 1'b1;
            queue_due(r);
        end
        else if (!joined) begin
            r.event_res = hmt_pkg::EV_TICK_IGNORED;
            r.last      = 1'b1;
            queue_due(r);
        end
        else begin
            for (int i = 0; i < DEPTH; i++) begin
                age = it.now - mt_stamp[i];
                if (mt_valid[i] && age > {16'd0, age_limit}) begin
                    mt_valid[i] = 1'b0;
                    r.event_res = hmt_pkg::EV_REMOVED;
                    r.peer_id   = mt_id[i];
                    r.peer_port = mt_port[i];
                    r.beat_out  = mt_beat[i];
                    queue_due(r);
                end
            end
            own_beat = own_beat + 1'b1;
            merge_heartbeat(own_id, own_port, own_beat, it.now, ev, kept);
            r.event_res = hmt_pkg::EV_TICK_DONE;
            r.peer_id   = own_id;
            r.peer_port = own_port;
            r.beat_out  = own_beat;
            r.last      = 1'b1;
            queue_due(r);
        end
    endfunction

    function automatic hmt_pkg::req_item_t compose_item(
        input logic [hmt_pkg::CMD_W-1:0] cmd,
        input logic [hmt_pkg::ID_W-1:0] id,
        input logic [hmt_pkg::PORT_W-1:0] port,
        input logic [hmt_pkg::BEAT_W-1:0] hb,
        input logic [hmt_pkg::STAMP_W-1:0] now);
        hmt_pkg::req_item_t it;
        it.command     = cmd;
        it.member_id   = id;
        it.member_port = port;
        it.heartbeat   = hb;
        it.now         = now;
        return it;
    endfunction

    // Random traffic: mostly well-formed gossip about pool peers and ticks on a
    // moving clock, some messages about the node itself, and a little noise.
    function automatic hmt_pkg::req_item_t draw_item();
        hmt_pkg::req_item_t it;
        int unsigned roll;
        int unsigned sel;
        int unsigned k;
        it.command     = 2'($urandom_range(0, 3));
        it.member_id   = $urandom;
        it.member_port = 16'($urandom);
        it.heartbeat   = $urandom;
        it.now         = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return it;
        if (roll < 30) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                wall_ticks = wall_ticks + $urandom_range(0, 3);
            else if (sel < 9)
                wall_ticks = wall_ticks + $urandom_range(0, 2 * age_limit + 4);
            else
                wall_ticks = wall_ticks + $urandom_range(0, 80000);
            it.command = hmt_pkg::CMD_TICK;
            it.now     = wall_ticks;
            return it;
        end
        case ($urandom_range(0, 2))
            0:       it.command = hmt_pkg::CMD_JOIN_REQ;
            1:       it.command = hmt_pkg::CMD_JOIN_REPLY;
            default: it.command = hmt_pkg::CMD_GOSSIP;
        endcase
        it.now = wall_ticks;
        if (roll < 36) begin
            it.member_id   = own_id;
            it.member_port = own_port;
            it.heartbeat   = own_beat + $urandom_range(0, 2);
            return it;
        end
        k = $urandom_range(0, POOL_SIZE - 1);
        it.member_id   = pool_id[k];
        it.member_port = pool_port[k];
        sel = $urandom_range(0, 9);
        if (sel < 7)
            it.heartbeat = pool_beat[k] + $urandom_range(0, 3);
        else if (sel < 9)
            it.heartbeat = pool_beat[k] - $urandom_range(0, 2);
        else
            it.heartbeat = $urandom;
        if (it.heartbeat > pool_beat[k])
            pool_beat[k] = it.heartbeat;
        return it;
    endfunction

    // Drive one register write and mirror it; the caller drops cfg_we afterwards.
    task automatic write_reg(input logic [hmt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hmt_pkg::CFG_W-1:0] val);
        logic own0;
        own0 = mt_valid[0] && mt_id[0] == own_id && mt_port[0] == own_port;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            hmt_pkg::CFG_SELF_ID:
            begin
                own_id = val[hmt_pkg::ID_W-1:0];
                if (own0)
                    mt_id[0] = own_id;
            end
            hmt_pkg::CFG_SELF_PORT:
            begin
                own_port = val[hmt_pkg::PORT_W-1:0];
                if (own0)
                    mt_port[0] = own_port;
            end
            hmt_pkg::CFG_TIMEOUT:
                age_limit = val[hmt_pkg::TMO_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold until every queued beat went in, every result came out and the
    // block is ready again, so that registers can be written safely.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || req_valid || due_events.size() != 0 || !req_ready);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A gap
    // only starts once the current beat is gone, so valid never drops
    // before acceptance.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned idle_left = 0;

    always @(posedge clk) begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_ready) begin
            if (idle_left != 0) begin
                idle_left <= idle_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_q.size() != 0) begin
                req_valid <= 1'b1;
                req_data  <= pending_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 8);
                    // Spread gap lengths across the whole sweep of one item.
                    case ($urandom_range(0, 3))
                        1:       idle_left <= steady ? 0 : $urandom_range(1, 5);
                        2:       idle_left <= steady ? 0 : $urandom_range(6, 45);
                        default: idle_left <= 0;
                    endcase
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating stall pattern that is reloaded
    // now and then; one long hold-off lets the output back up into the
    // request side.
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_done = 1'b0;

    always @(posedge clk) begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (want_holdoff && !holdoff_done) begin
            holdoff_done <= 1'b1;
            holdoff_left <= 600;
            rsp_ready    <= 1'b0;
        end
        else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_ready    <= 1'b0;
        end
        else begin
            rsp_ready <= stall_pattern[0];
            if (pattern_age == 0) begin
                pattern_age <= $urandom_range(16, 128);
                // Keep at least one ready bit so that ready returns in every rotation.
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= 16'hFFFF;
                    3:       stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
                    default: stall_pattern <= 16'($urandom) | 16'h0001;
                endcase
            end
            else begin
                pattern_age   <= pattern_age - 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted request beat, then check every
    // accepted result beat against the oldest prediction. Prediction runs
    // first so that both sides stay in one process.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        hmt_pkg::rsp_item_t want;
        if (rst_n) begin
            if (req_valid && req_ready)
                membership_update(req_data);
            if (rsp_valid && rsp_ready) begin
                if (due_events.size() == 0) begin
                    $error("unexpected result beat: event_res %0d peer_id %h",
                           rsp_data.event_res, rsp_data.peer_id);
                    mismatch_cnt++;
                end
                else begin
                    want = due_events.pop_front();
                    if (rsp_data.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, rsp_data.event_res);
                        mismatch_cnt++;
                    end
                    if (rsp_data.peer_id !== want.peer_id) begin
                        $error("peer_id: expected %h, got %h", want.peer_id, rsp_data.peer_id);
                        mismatch_cnt++;
                    end
                    if (rsp_data.peer_port !== want.peer_port) begin
                        $error("peer_port: expected %h, got %h",
                               want.peer_port, rsp_data.peer_port);
                        mismatch_cnt++;
                    end
                    if (rsp_data.beat_out !== want.beat_out) begin
                        $error("beat_out: expected %h, got %h", want.beat_out, rsp_data.beat_out);
                        mismatch_cnt++;
                    end
                    if (rsp_data.send_reply !== want.send_reply) begin
                        $error("send_reply: expected %b, got %b",
                               want.send_reply, rsp_data.send_reply);
                        mismatch_cnt++;
                    end
                    if (rsp_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, rsp_data.last);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, then phases of register writes and traffic.
    // ------------------------------------------------------------------
    initial begin
        logic [hmt_pkg::STAMP_W-1:0] t0;
        for (int i = 0; i < DEPTH; i++) begin
            mt_valid[i] = 1'b0;
            mt_id[i]    = '0;
            mt_port[i]  = '0;
            mt_beat[i]  = '0;
            mt_stamp[i] = '0;
        end
        mt_valid[0] = 1'b1;
        own_beat    = '0;
        joined      = 1'b0;
        own_id      = '0;
        own_port    = '0;
        age_limit   = hmt_pkg::TIMEOUT_RESET;
        // Every eighth peer shares its id with the one before, so only the
        // port tells them apart.
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_id[k]   = (k % 8 == 7) ? pool_id[k - 1] : $urandom;
            pool_port[k] = 16'($urandom);
            pool_beat[k] = $urandom_range(0, 50);
        end
        wall_ticks = $urandom;
        t0 = 32'd1000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short timeout, own address set while entry zero holds it.
        write_reg(hmt_pkg::CFG_SELF_ID, $urandom);
        write_reg(hmt_pkg::CFG_SELF_PORT, {16'($urandom), 16'($urandom)});
        write_reg(hmt_pkg::CFG_TIMEOUT, 32'd5);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        // A tick before joining is ignored.
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, t0));
        // Add, equal and lower beats are stale, then a newer one refreshes.
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h0000_0001, 16'h0001, 32'd10, t0));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h0000_0001, 16'h0001, 32'd10, t0));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h0000_0001, 16'h0001, 32'd9, t0));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h0000_0001, 16'h0001, 32'd11,
                               t0 + 1));
        // Join request at the all-ones extreme, then again with a stale beat.
        queue_req(compose_item(hmt_pkg::CMD_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                               t0 + 1));
        queue_req(compose_item(hmt_pkg::CMD_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, 32'd0,
                               t0 + 1));
        // Join reply puts the node into the group.
        queue_req(compose_item(hmt_pkg::CMD_JOIN_REPLY, 32'h8000_0000, 16'h8000, 32'd0,
                               t0 + 2));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'd0, 16'd0, 32'd0, 32'd0));
        // Gossip about the node itself with beat zero is stale.
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, own_id, own_port, 32'd0, t0 + 2));
        // Ticks: removal of the own entry and of an old stamp, then a quiet
        // tick, then a sweep that clears everything and re-adds the own entry.
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, t0 + 3));
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, t0 + 3));
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, t0 + 20));
        // Time wraps past 2^32 between these two.
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h5555_5555, 16'hAAAA, 32'hFFFF_FFFF,
                               32'hFFFF_FFFE));
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, 32'd2));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h5555_5555, 16'hAAAA, 32'd0, 32'd2));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'hAAAA_AAAA, 16'h5555, 32'd1, 32'd3));
        wait_drained();

        // Directed: zero timeout keeps only entries stamped at the tick time.
        write_reg(hmt_pkg::CFG_TIMEOUT, 32'd0);
        cfg_we <= 1'b0;
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, 32'd3));
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, 32'd3));
        queue_req(compose_item(hmt_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, 32'd4));
        queue_req(compose_item(hmt_pkg::CMD_GOSSIP, 32'h1234_5678, 16'h0000, 32'd5, 32'd4));
        queue_req(compose_item(hmt_pkg::CMD_JOIN_REPLY, 32'h1234_5678, 16'h0000, 32'd6,
                               32'd4));
        wait_drained();

        // Random: longest timeout so the table fills and drops peers; move
        // the own address and hold the receiver off once mid-phase.
        write_reg(hmt_pkg::CFG_SELF_ID, $urandom);
        write_reg(hmt_pkg::CFG_SELF_PORT, $urandom);
        write_reg(hmt_pkg::CFG_TIMEOUT, 32'd65535);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        repeat (120) queue_req(draw_item());
        while (pending_q.size() > 80)
            @(posedge clk);
        want_holdoff <= 1'b1;
        wait_drained();

        // Random: smallest nonzero timeout, zero own address, no sender gaps.
        write_reg(hmt_pkg::CFG_SELF_ID, 32'd0);
        write_reg(hmt_pkg::CFG_SELF_PORT, 32'd0);
        write_reg(hmt_pkg::CFG_TIMEOUT, 32'd1);
        cfg_we <= 1'b0;
        steady <= 1'b1;
        repeat (120) queue_req(draw_item());
        wait_drained();

        // Random: all-ones own address, moderate timeout.
        write_reg(hmt_pkg::CFG_SELF_ID, 32'hFFFF_FFFF);
        write_reg(hmt_pkg::CFG_SELF_PORT, 32'h0000_FFFF);
        write_reg(hmt_pkg::CFG_TIMEOUT, $urandom_range(2, 40));
        cfg_we <= 1'b0;
        steady <= 1'b0;
        repeat (110) queue_req(draw_item());
        wait_drained();

        // Let any straggling beat show up before the verdict.
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
